// ===== src/cube_symmetry_point_and_face_transform_macros.svh =====
// Assertion macros for the cube symmetry transform block.
// Included by the RTL files that carry concurrent assertions; expects clk and rst in scope.
`ifndef CUBE_SYMMETRY_POINT_AND_FACE_TRANSFORM_MACROS_SVH
`define CUBE_SYMMETRY_POINT_AND_FACE_TRANSFORM_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CSPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/cspt_pkg.sv =====
// Shared constants and lookup tables for the cube symmetry transform.
// No dependencies; used by cspt_xform, the top level and the testbench.
package cspt_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int NUM_ROT        = 24;
  localparam int NUM_FACES      = 6;
  localparam int ROT_BITS       = 5;
  localparam int FACE_BITS      = 3;

  // Swizzle entry: bits [1:0] pick the source axis, bit 2 takes extent - value.
  typedef logic [2:0] swz_t;
  typedef logic [FACE_BITS-1:0] face_t;

  localparam swz_t SWIZZLE [0:NUM_ROT-1][0:2] = '{
    '{3'd0, 3'd1, 3'd2},
    '{3'd0, 3'd6, 3'd1},
    '{3'd0, 3'd5, 3'd6},
    '{3'd0, 3'd2, 3'd5},
    '{3'd2, 3'd1, 3'd4},
    '{3'd4, 3'd1, 3'd6},
    '{3'd6, 3'd1, 3'd0},
    '{3'd5, 3'd0, 3'd2},
    '{3'd4, 3'd5, 3'd2},
    '{3'd1, 3'd4, 3'd2},
    '{3'd4, 3'd2, 3'd1},
    '{3'd4, 3'd6, 3'd5},
    '{3'd2, 3'd5, 3'd0},
    '{3'd6, 3'd5, 3'd4},
    '{3'd1, 3'd0, 3'd6},
    '{3'd5, 3'd4, 3'd6},
    '{3'd1, 3'd2, 3'd0},
    '{3'd2, 3'd0, 3'd1},
    '{3'd2, 3'd4, 3'd5},
    '{3'd5, 3'd6, 3'd0},
    '{3'd6, 3'd4, 3'd1},
    '{3'd5, 3'd2, 3'd4},
    '{3'd1, 3'd6, 3'd4},
    '{3'd6, 3'd0, 3'd5}
  };

  // Face direction after rotation, indexed [face][rotation].
  localparam face_t FACE_MAP [0:NUM_FACES-1][0:NUM_ROT-1] = '{
    '{3'd0,3'd0,3'd0,3'd0,3'd5,3'd1,3'd4,3'd2,3'd1,3'd3,3'd1,3'd1,
      3'd4,3'd5,3'd2,3'd3,3'd4,3'd2,3'd3,3'd4,3'd3,3'd5,3'd5,3'd2},
    '{3'd1,3'd1,3'd1,3'd1,3'd4,3'd0,3'd5,3'd3,3'd0,3'd2,3'd0,3'd0,
      3'd5,3'd4,3'd3,3'd2,3'd5,3'd3,3'd2,3'd5,3'd2,3'd4,3'd4,3'd3},
    '{3'd2,3'd4,3'd3,3'd5,3'd2,3'd2,3'd2,3'd1,3'd3,3'd0,3'd4,3'd5,
      3'd3,3'd3,3'd0,3'd1,3'd0,3'd4,3'd5,3'd1,3'd4,3'd1,3'd0,3'd5},
    '{3'd3,3'd5,3'd2,3'd4,3'd3,3'd3,3'd3,3'd0,3'd2,3'd1,3'd5,3'd4,
      3'd2,3'd2,3'd1,3'd0,3'd1,3'd5,3'd4,3'd0,3'd5,3'd0,3'd1,3'd4},
    '{3'd4,3'd3,3'd5,3'd2,3'd0,3'd5,3'd1,3'd4,3'd4,3'd4,3'd2,3'd3,
      3'd0,3'd1,3'd5,3'd5,3'd2,3'd0,3'd0,3'd3,3'd1,3'd2,3'd3,3'd1},
    '{3'd5,3'd2,3'd4,3'd3,3'd1,3'd4,3'd0,3'd5,3'd5,3'd5,3'd3,3'd2,
      3'd1,3'd0,3'd4,3'd4,3'd3,3'd1,3'd1,3'd2,3'd0,3'd3,3'd2,3'd0}
  };

endpackage

// ===== src/cspt_xform.sv =====
// Combinational symmetry transform of one point and one face direction.
// Depends on cspt_pkg for the swizzle and face tables.
module cspt_xform #(
  parameter int COORD_BITS = cspt_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]          pos_x,
  input  logic [COORD_BITS-1:0]          pos_y,
  input  logic [COORD_BITS-1:0]          pos_z,
  input  logic [COORD_BITS-1:0]          extent_x,
  input  logic [COORD_BITS-1:0]          extent_y,
  input  logic [COORD_BITS-1:0]          extent_z,
  input  logic                           invert_flag,
  input  logic [cspt_pkg::ROT_BITS-1:0]  rotation_code,
  input  logic [cspt_pkg::FACE_BITS-1:0] face_dir,
  output logic [COORD_BITS-1:0]          new_x,
  output logic [COORD_BITS-1:0]          new_y,
  output logic [COORD_BITS-1:0]          new_z,
  output logic [cspt_pkg::FACE_BITS-1:0] new_face,
  output logic                           out_of_range
);

  logic [COORD_BITS-1:0] pos [0:2];
  logic [COORD_BITS-1:0] ext [0:2];
  logic [COORD_BITS-1:0] p   [0:2];
  logic [COORD_BITS-1:0] q   [0:2];
  logic [COORD_BITS-1:0] r   [0:2];
  logic                  rot_ok;
  cspt_pkg::face_t       face_inv;

  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;
  assign ext[0] = extent_x;
  assign ext[1] = extent_y;
  assign ext[2] = extent_z;

  assign rot_ok = rotation_code < cspt_pkg::ROT_BITS'(cspt_pkg::NUM_ROT);

  assign out_of_range = (pos_x > extent_x) || (pos_y > extent_y) || (pos_z > extent_z);

  // Inversion, then the reflected copy of every component.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p[i] = invert_flag ? (ext[i] - pos[i]) : pos[i];
      q[i] = ext[i] - p[i];
    end
  end

  always_comb begin
    cspt_pkg::swz_t s;
    logic [1:0]     src;
    for (int i = 0; i < 3; i++) begin
      s    = cspt_pkg::SWIZZLE[rotation_code][i];
      src  = (s[1:0] == 2'd3) ? 2'd2 : s[1:0];
      r[i] = p[i];
      if (rot_ok) begin
        r[i] = s[2] ? q[src] : p[src];
      end
    end
  end

  assign new_x = r[0];
  assign new_y = r[1];
  assign new_z = r[2];

  // Inversion swaps a face with its opposite: the low code bit marks Min/Max.
  assign face_inv = invert_flag ? (face_dir ^ cspt_pkg::FACE_BITS'(1)) : face_dir;

  always_comb begin
    new_face = face_dir;
    if (face_dir < cspt_pkg::FACE_BITS'(cspt_pkg::NUM_FACES)) begin
      new_face = rot_ok ? cspt_pkg::FACE_MAP[face_inv][rotation_code] : face_inv;
    end
  end

endmodule

// ===== src/cube_symmetry_point_and_face_transform.sv =====
// Top level of the cube symmetry transform: input register, transform, result register.
// Depends on cspt_pkg, cspt_xform and the assertion macro header.
//
//   Channel   Direction  Handshake           Payload
//   s_*       in         s_tvalid/s_tready   point, extent, inversion, rotation, face
//   m_*       out        m_tvalid/m_tready   transformed point, face, out-of-range flag
//
// Each item is held in the input register and then moves to the result register,
// once that register can load, and its result is offered from there.
// One item is accepted per cycle while the output side keeps taking results.
// Reset (rst, synchronous, active high) empties both registers; no clearing pass.
// When the output stalls, the result register holds and the input register still
// takes one more item, so the input side sees ready drop only when both are full.

`include "cube_symmetry_point_and_face_transform_macros.svh"

module cube_symmetry_point_and_face_transform #(
  parameter int COORD_BITS = cspt_pkg::COORD_BITS_DEF,
  localparam int IN_BITS   = 6 * COORD_BITS + 1 + cspt_pkg::ROT_BITS + cspt_pkg::FACE_BITS,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = 3 * COORD_BITS + cspt_pkg::FACE_BITS + 1,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // Fields from bit 0: pos_x, pos_y, pos_z, extent_x, extent_y, extent_z,
  // invert_flag, rotation_code, face_dir, zero fill.
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // Fields from bit 0: new_x, new_y, new_z, new_face, out_of_range, zero fill.
  output logic [OUT_W-1:0] m_tdata
);

  localparam int CB = COORD_BITS;

  // Input register: valid flag plus the packed item.
  logic               in_valid;
  logic [IN_BITS-1:0] in_item;
  // Result register.
  logic                           out_valid;
  logic [CB-1:0]                  res_x;
  logic [CB-1:0]                  res_y;
  logic [CB-1:0]                  res_z;
  logic [cspt_pkg::FACE_BITS-1:0] res_face;
  logic                           res_oor;

  logic                           advance;
  logic                           s_acc;
  logic [CB-1:0]                  c_x;
  logic [CB-1:0]                  c_y;
  logic [CB-1:0]                  c_z;
  logic [cspt_pkg::FACE_BITS-1:0] c_face;
  logic                           c_oor;

  // The result register can load when it is empty or being drained this cycle.
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign s_acc    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      in_item <= s_tdata[IN_BITS-1:0];
    end
    if (advance && in_valid) begin
      res_x    <= c_x;
      res_y    <= c_y;
      res_z    <= c_z;
      res_face <= c_face;
      res_oor  <= c_oor;
    end
  end

  cspt_xform #(
    .COORD_BITS(COORD_BITS)
  ) u_xform (
    .pos_x        (in_item[0*CB +: CB]),
    .pos_y        (in_item[1*CB +: CB]),
    .pos_z        (in_item[2*CB +: CB]),
    .extent_x     (in_item[3*CB +: CB]),
    .extent_y     (in_item[4*CB +: CB]),
    .extent_z     (in_item[5*CB +: CB]),
    .invert_flag  (in_item[6*CB]),
    .rotation_code(in_item[6*CB+1 +: cspt_pkg::ROT_BITS]),
    .face_dir     (in_item[6*CB+1+cspt_pkg::ROT_BITS +: cspt_pkg::FACE_BITS]),
    .new_x        (c_x),
    .new_y        (c_y),
    .new_z        (c_z),
    .new_face     (c_face),
    .out_of_range (c_oor)
  );

  assign m_tvalid = out_valid;

  always_comb begin
    m_tdata                 = '0;
    m_tdata[OUT_BITS-1:0]   = {res_oor, res_face, res_z, res_y, res_x};
  end

  // An empty input register must always be able to take an item.
  `CSPT_ASSERT_NOW(a_empty_ready, !in_valid, s_tready, "input register empty but not ready")
  // An accepted item occupies the input register in the next cycle.
  `CSPT_ASSERT_NEXT(a_acc_loads, s_acc, in_valid, "accepted item not held")
  // A held item that moves on shows up as a result in the next cycle.
  `CSPT_ASSERT_NEXT(a_move_out, in_valid && advance, out_valid, "item lost between stages")
  // A valid face never maps to an invalid code.
  `CSPT_ASSERT_NOW(a_face_ok,
    in_valid && (in_item[6*CB+1+cspt_pkg::ROT_BITS +: cspt_pkg::FACE_BITS] <
                 cspt_pkg::FACE_BITS'(cspt_pkg::NUM_FACES)),
    c_face < cspt_pkg::FACE_BITS'(cspt_pkg::NUM_FACES), "face mapped out of range")

endmodule

// ===== tb/cube_symmetry_point_and_face_transform_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the cube symmetry transform: random bursts on the input
// stream, a stalling output stream, and a scoreboard fed by a behavioral predictor.
// Depends on cspt_pkg and the cube_symmetry_point_and_face_transform top level.

module cube_symmetry_point_and_face_transform_tb;

  localparam int CW = cspt_pkg::COORD_BITS_DEF;

  // The run is stopped here no matter what. The slowest legal run stays far below this.
  localparam int CYCLE_LIMIT = 300000;

  // Rotation codes that matter on their own. Codes from NUM_ROT up are unused
  // and must leave both point and face unrotated.
  localparam logic [4:0] ROT_IDENTITY     = 5'd0;
  localparam logic [4:0] ROT_CORNER_LAST  = 5'd23;
  localparam logic [4:0] ROT_FIRST_UNUSED = 5'(cspt_pkg::NUM_ROT);
  localparam logic [4:0] ROT_LAST_UNUSED  = 5'd31;

  // Bit 2 of an axis pick takes the mirrored copy (extent - value) of the source.
  localparam logic [2:0] MIRROR = 3'd4;

  typedef logic [CW-1:0] coord_t;

  typedef enum logic [2:0] {
    FACE_MIN_X   = 3'd0,
    FACE_MAX_X   = 3'd1,
    FACE_MIN_Y   = 3'd2,
    FACE_MAX_Y   = 3'd3,
    FACE_MIN_Z   = 3'd4,
    FACE_MAX_Z   = 3'd5,
    FACE_BOGUS_A = 3'd6,
    FACE_BOGUS_B = 3'd7
  } face_code_t;

  // Input item, laid out so that pos_x sits in bit 0 of tdata.
  typedef struct packed {
    logic [2:0] fill;
    face_code_t face;
    logic [4:0] rotation;
    logic       invert;
    coord_t     ext_z;
    coord_t     ext_y;
    coord_t     ext_x;
    coord_t     pos_z;
    coord_t     pos_y;
    coord_t     pos_x;
  } xform_item_t;

  // Result item, new_x in bit 0.
  typedef struct packed {
    logic [5:0] fill;
    logic       out_of_range;
    face_code_t face;
    coord_t     z;
    coord_t     y;
    coord_t     x;
  } xform_result_t;

  // For each rotation and each output axis: which input axis feeds it, and
  // whether it is mirrored against the extent of that source axis.
  localparam logic [2:0] AXIS_PICK [0:23][0:2] = '{
    '{3'd0,          3'd1,          3'd2},
    '{3'd0,          3'd2 | MIRROR, 3'd1},
    '{3'd0,          3'd1 | MIRROR, 3'd2 | MIRROR},
    '{3'd0,          3'd2,          3'd1 | MIRROR},
    '{3'd2,          3'd1,          3'd0 | MIRROR},
    '{3'd0 | MIRROR, 3'd1,          3'd2 | MIRROR},
    '{3'd2 | MIRROR, 3'd1,          3'd0},
    '{3'd1 | MIRROR, 3'd0,          3'd2},
    '{3'd0 | MIRROR, 3'd1 | MIRROR, 3'd2},
    '{3'd1,          3'd0 | MIRROR, 3'd2},
    '{3'd0 | MIRROR, 3'd2,          3'd1},
    '{3'd0 | MIRROR, 3'd2 | MIRROR, 3'd1 | MIRROR},
    '{3'd2,          3'd1 | MIRROR, 3'd0},
    '{3'd2 | MIRROR, 3'd1 | MIRROR, 3'd0 | MIRROR},
    '{3'd1,          3'd0,          3'd2 | MIRROR},
    '{3'd1 | MIRROR, 3'd0 | MIRROR, 3'd2 | MIRROR},
    '{3'd1,          3'd2,          3'd0},
    '{3'd2,          3'd0,          3'd1},
    '{3'd2,          3'd0 | MIRROR, 3'd1 | MIRROR},
    '{3'd1 | MIRROR, 3'd2 | MIRROR, 3'd0},
    '{3'd2 | MIRROR, 3'd0 | MIRROR, 3'd1},
    '{3'd1 | MIRROR, 3'd2,          3'd0 | MIRROR},
    '{3'd1,          3'd2 | MIRROR, 3'd0 | MIRROR},
    '{3'd2 | MIRROR, 3'd0,          3'd1 | MIRROR}
  };

  // Face direction after each rotation, indexed [face][rotation].
  localparam logic [2:0] FACE_AFTER [0:5][0:23] = '{
    '{0,0,0,0,5,1,4,2,1,3,1,1,4,5,2,3,4,2,3,4,3,5,5,2},
    '{1,1,1,1,4,0,5,3,0,2,0,0,5,4,3,2,5,3,2,5,2,4,4,3},
    '{2,4,3,5,2,2,2,1,3,0,4,5,3,3,0,1,0,4,5,1,4,1,0,5},
    '{3,5,2,4,3,3,3,0,2,1,5,4,2,2,1,0,1,5,4,0,5,0,1,4},
    '{4,3,5,2,0,5,1,4,4,4,2,3,0,1,5,5,2,0,0,3,1,2,3,1},
    '{5,2,4,3,1,4,0,5,5,5,3,2,1,0,4,4,3,1,1,2,0,3,2,0}
  };

  // Every input starts at a known value; nothing is left floating before reset.
  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  xform_item_t   s_tdata = '0;   // pos_x, pos_y, pos_z, extent_x..z, invert, rotation, face
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  xform_result_t m_tdata;        // new_x, new_y, new_z, new_face, out_of_range

  xform_item_t   pending_items[$];     // stimulus not yet offered to the block
  xform_result_t expected_results[$];  // transforms predicted for accepted items
  int            drain_marks[$];       // item counts at which the sender waits for a drain

  int sent_count   = 0;
  int result_count = 0;
  int fail_count   = 0;
  int cycle_count  = 0;

  cube_symmetry_point_and_face_transform u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // Predicts the result of one item. The out-of-range flag looks at the raw
  // inputs; inversion mirrors every axis first, then the rotation picks and
  // optionally mirrors axes. All differences wrap at the coordinate width.
  function automatic xform_result_t apply_symmetry(input xform_item_t it);
    coord_t        pt [3];
    coord_t        lim [3];
    coord_t        flip [3];
    coord_t        moved [3];
    logic [2:0]    pick;
    logic [2:0]    f;
    xform_result_t res;
    pt[0]  = it.pos_x;
    pt[1]  = it.pos_y;
    pt[2]  = it.pos_z;
    lim[0] = it.ext_x;
    lim[1] = it.ext_y;
    lim[2] = it.ext_z;
    res = '0;
    for (int a = 0; a < 3; a++) begin
      if (pt[a] > lim[a]) res.out_of_range = 1'b1;
    end
    if (it.invert) begin
      for (int a = 0; a < 3; a++) pt[a] = lim[a] - pt[a];
    end
    for (int a = 0; a < 3; a++) flip[a] = lim[a] - pt[a];
    for (int a = 0; a < 3; a++) begin
      if (it.rotation < ROT_FIRST_UNUSED) begin
        pick = AXIS_PICK[it.rotation][a];
        moved[a] = (pick & MIRROR) != 3'd0 ? flip[pick[1:0]] : pt[pick[1:0]];
      end else begin
        moved[a] = pt[a];
      end
    end
    // Face codes six and seven are invalid markers and pass through untouched.
    f = it.face;
    if (f <= FACE_MAX_Z) begin
      if (it.invert) f = f ^ 3'd1;
      if (it.rotation < ROT_FIRST_UNUSED) f = FACE_AFTER[f][it.rotation];
    end
    res.x    = moved[0];
    res.y    = moved[1];
    res.z    = moved[2];
    res.face = face_code_t'(f);
    return res;
  endfunction

  function automatic xform_item_t make_item(input coord_t px, input coord_t py,
                                            input coord_t pz, input coord_t ex,
                                            input coord_t ey, input coord_t ez,
                                            input logic inv, input logic [4:0] rot,
                                            input logic [2:0] face);
    xform_item_t it;
    it          = '0;
    it.pos_x    = px;
    it.pos_y    = py;
    it.pos_z    = pz;
    it.ext_x    = ex;
    it.ext_y    = ey;
    it.ext_z    = ez;
    it.invert   = inv;
    it.rotation = rot;
    it.face     = face_code_t'(face);
    return it;
  endfunction

  // Sender. An item on the bus is held until it is taken; only then may the
  // next one be offered. Items go out in bursts with gaps between them, except
  // in every third block of 128 items where the sender runs flat out. At the
  // drain marks it stops until every predicted result has been collected.
  always @(posedge clk) begin : sender
    int   burst_left;
    int   gap_left;
    logic offer;
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_symmetry(s_tdata));
        sent_count++;
      end
      if (!s_tvalid || s_tready) begin
        offer = 1'b0;
        if (drain_marks.size() != 0 && sent_count == drain_marks[0]) begin
          if (expected_results.size() == 0) drain_marks.pop_front();
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() != 0) begin
          offer = 1'b1;
          s_tdata <= pending_items.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(12, 0);
            if ((sent_count / 128) % 3 == 0) gap_left = 0;
            else if ($urandom_range(3) == 0) gap_left = $urandom_range(24, 8);
            else gap_left = $urandom_range(3, 0);
          end
        end
        s_tvalid <= offer;
      end
    end
  end

  // Receiver. Ready follows a rotating 16-bit pattern that is reloaded now and
  // then: always ready, a random pattern, a mostly ready or a mostly stalled one.
  always @(posedge clk) begin : receiver
    logic [15:0] ready_pattern;
    int          ready_left;
    if (rst) begin
      m_tready      <= 1'b0;
      ready_pattern = 16'hffff;
      ready_left    = 0;
    end else begin
      if (ready_left == 0) begin
        case ($urandom_range(3))
          0:       ready_pattern = 16'hffff;
          1:       ready_pattern = 16'($urandom);
          2:       ready_pattern = 16'($urandom) | 16'($urandom);
          default: ready_pattern = 16'($urandom) & 16'($urandom);
        endcase
        ready_left = $urandom_range(200, 20);
      end else begin
        ready_left--;
      end
      m_tready      <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end
  end

  // Scoreboard: every result taken from the block is checked against the
  // oldest prediction, field by field.
  always @(posedge clk) begin : result_check
    xform_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result item: x=%0d y=%0d z=%0d face=%0d oor=%0b",
                   m_tdata.x, m_tdata.y, m_tdata.z, m_tdata.face, m_tdata.out_of_range);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata.x !== want.x || m_tdata.y !== want.y || m_tdata.z !== want.z ||
            m_tdata.face !== want.face || m_tdata.out_of_range !== want.out_of_range) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result item %0d: expected x=%0d y=%0d z=%0d face=%0d oor=%0b,",
                     result_count, want.x, want.y, want.z, want.face, want.out_of_range,
                     " got x=%0d y=%0d z=%0d face=%0d oor=%0b",
                     m_tdata.x, m_tdata.y, m_tdata.z, m_tdata.face, m_tdata.out_of_range);
        end
      end
      result_count++;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cube_symmetry_point_and_face_transform_tb: errors");
      $finish;
    end
  end

  initial begin : stimulus
    coord_t     pos [3];
    coord_t     ext [3];
    logic [4:0] rot;
    logic [2:0] face;
    int         directed_count;
    int         total_items;

    // Directed part. First every rotation once, with the face code walking
    // through all eight values (invalid markers included) and inversion toggling.
    for (int k = 0; k < cspt_pkg::NUM_ROT; k++)
      pending_items.push_back(make_item(coord_t'(k * 41), coord_t'(1023 - k * 29),
                                        coord_t'(k * 7), '1, '1, coord_t'(200 + k),
                                        1'((k / 2) % 2), 5'(k), 3'(k % 8)));
    // Everything zero, and everything at its maximum.
    pending_items.push_back(make_item('0, '0, '0, '0, '0, '0, 1'b0, ROT_IDENTITY,
                                      FACE_MIN_X));
    pending_items.push_back(make_item('1, '1, '1, '1, '1, '1, 1'b1, ROT_CORNER_LAST,
                                      FACE_MAX_Z));
    // Points beyond the extent, so that the mirrored copies wrap around.
    pending_items.push_back(make_item('1, 10'd5, 10'd600, '0, 10'd4, 10'd599, 1'b1,
                                      5'd13, FACE_MIN_Y));
    // Unused rotation codes: no rotation, inversion still applied.
    pending_items.push_back(make_item(10'd3, 10'd500, 10'd1000, 10'd10, 10'd700, '1,
                                      1'b1, ROT_FIRST_UNUSED, FACE_MAX_X));
    pending_items.push_back(make_item(10'd900, 10'd2, 10'd77, 10'd899, 10'd1, 10'd77,
                                      1'b0, ROT_LAST_UNUSED, FACE_BOGUS_B));
    directed_count = pending_items.size();

    // Random part. Extents favor the corners of their range; most points lie
    // inside the box, some on its faces and some anywhere at all.
    for (int n = 0; n < 650; n++) begin
      for (int a = 0; a < 3; a++) begin
        case ($urandom_range(7))
          0:       ext[a] = '1;
          1:       ext[a] = '0;
          2:       ext[a] = coord_t'($urandom_range(15));
          default: ext[a] = coord_t'($urandom);
        endcase
        case ($urandom_range(9))
          0:       pos[a] = ext[a];
          1:       pos[a] = '0;
          2:       pos[a] = coord_t'($urandom);
          default: pos[a] = coord_t'($urandom_range(ext[a], 0));
        endcase
      end
      rot  = ($urandom_range(9) == 0) ? 5'($urandom_range(ROT_LAST_UNUSED, ROT_FIRST_UNUSED))
                                      : 5'($urandom_range(ROT_CORNER_LAST, ROT_IDENTITY));
      face = ($urandom_range(7) == 0) ? 3'($urandom_range(FACE_BOGUS_B, FACE_BOGUS_A))
                                      : 3'($urandom_range(FACE_MAX_Z, FACE_MIN_X));
      pending_items.push_back(make_item(pos[0], pos[1], pos[2], ext[0], ext[1], ext[2],
                                        1'($urandom_range(1)), rot, face));
    end
    total_items = pending_items.size();

    // The sender drains the block after the directed part and once mid-run.
    drain_marks.push_back(directed_count);
    drain_marks.push_back(directed_count + 320);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait until every item has been taken by the block, then for its result.
    while (sent_count < total_items) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    // Keep the clock running to catch stray results from the two-stage pipeline.
    repeat (6) @(posedge clk);

    if (fail_count == 0) begin
      $display("cube_symmetry_point_and_face_transform_tb: clean");
    end else begin
      $display("cube_symmetry_point_and_face_transform_tb: errors");
    end
    $finish;
  end

endmodule
